// ===== hdl/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Banker's safety and request: shared types
// Item layouts, status and function codes, table command, lane helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package bsr_pkg;

    localparam int LANES     = 4;
    localparam int LANE_W    = 8;
    localparam int WORK_W    = 13;
    localparam int ROW_W     = LANES * LANE_W;
    localparam int PROC_W    = 4;

    localparam logic [2:0] FN_LOAD_MAX   = 3'd0;
    localparam logic [2:0] FN_LOAD_ALLOC = 3'd1;
    localparam logic [2:0] FN_LOAD_AVAIL = 3'd2;
    localparam logic [2:0] FN_CHECK      = 3'd3;
    localparam logic [2:0] FN_REQUEST    = 3'd4;

    typedef enum logic [2:0] {
        ST_LOADED     = 3'd0,
        ST_SAFE       = 3'd1,
        ST_UNSAFE     = 3'd2,
        ST_EXC_NEED   = 3'd3,
        ST_EXC_AVAIL  = 3'd4,
        ST_BAD_PROC   = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0]        func;
        logic [PROC_W-1:0] process;
        logic [7:0]        amount_a;
        logic [7:0]        amount_b;
        logic [7:0]        amount_c;
        logic [7:0]        amount_d;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [PROC_W-1:0] seq_position;
        logic [PROC_W-1:0] process_id;
        logic              last_item;
    } t_out_item;

    typedef struct packed {
        logic [PROC_W-1:0] rd_addr;
        logic              we_max;
        logic              we_alloc;
        logic [PROC_W-1:0] wr_addr;
        logic [ROW_W-1:0]  wr_data;
    } t_tbl_cmd;

    function automatic logic [LANE_W-1:0] lane_of(input logic [ROW_W-1:0] v, input int k);
        return v[k*LANE_W +: LANE_W];
    endfunction

    function automatic logic [LANE_W-1:0] need_of(input logic [LANE_W-1:0] m,
                                                  input logic [LANE_W-1:0] a);
        return (m > a) ? (m - a) : '0;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/bsr_chan_if.sv =====
// ----------------------------------------------------------------------------
// Banker's safety and request: channel interface
// Valid/ready channel carrying one request or result item.
// ----------------------------------------------------------------------------
`default_nettype none
interface bsr_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bsr_tables.sv =====
// ----------------------------------------------------------------------------
// Banker's safety and request: claim and allocation tables
// Two synchronous memories sharing one read address, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bsr_tables #(
    parameter int NumProc = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bsr_pkg::t_tbl_cmd i_cmd,
    output logic [31:0]            o_max_q,
    output logic [31:0]            o_alloc_q
);
    import bsr_pkg::*;

    localparam int IW = (NumProc > 1) ? $clog2(NumProc) : 1;

    logic [ROW_W-1:0] r_max_mem   [NumProc];
    logic [ROW_W-1:0] r_alloc_mem [NumProc];
    logic [NumProc-1:0] r_max_vld;
    logic [NumProc-1:0] r_alloc_vld;
    logic [ROW_W-1:0] r_max_q;
    logic [ROW_W-1:0] r_alloc_q;
    logic r_max_qv;
    logic r_alloc_qv;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] wr_idx;

    assign rd_idx = i_cmd.rd_addr[IW-1:0];
    assign wr_idx = i_cmd.wr_addr[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.we_max) begin
            r_max_mem[wr_idx] <= i_cmd.wr_data;
        end
        if (i_cmd.we_alloc) begin
            r_alloc_mem[wr_idx] <= i_cmd.wr_data;
        end
        r_max_q   <= r_max_mem[rd_idx];
        r_alloc_q <= r_alloc_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vld   <= '0;
            r_alloc_vld <= '0;
            r_max_qv    <= 1'b0;
            r_alloc_qv  <= 1'b0;
        end else begin
            if (i_cmd.we_max) begin
                r_max_vld[wr_idx] <= 1'b1;
            end
            if (i_cmd.we_alloc) begin
                r_alloc_vld[wr_idx] <= 1'b1;
            end
            r_max_qv   <= r_max_vld[rd_idx];
            r_alloc_qv <= r_alloc_vld[rd_idx];
        end
    end

    assign o_max_q   = r_max_qv   ? r_max_q   : '0;
    assign o_alloc_q = r_alloc_qv ? r_alloc_q : '0;

endmodule
`default_nettype wire

// ===== hdl/bsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Banker's safety and request: sequencer
// Decodes requests, runs the safety scan over the tables, emits results.
// ----------------------------------------------------------------------------
`default_nettype none
module bsr_ctrl #(
    parameter int NumProc = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire bsr_pkg::t_in_item  i_in_data,
    output bsr_pkg::t_tbl_cmd       o_cmd,
    input  wire logic [31:0]        i_max_q,
    input  wire logic [31:0]        i_alloc_q,
    output logic                    o_res_valid,
    output bsr_pkg::t_out_item      o_res,
    input  wire logic               i_res_ready
);
    import bsr_pkg::*;

    localparam int IW = (NumProc > 1) ? $clog2(NumProc) : 1;
    localparam int CW = $clog2(NumProc + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_REQ   = 5'b00010,
        S_START = 5'b00100,
        S_SCAN  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_p, n_p;
    logic [IW-1:0] r_epos, n_epos;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NumProc-1:0] r_fin, n_fin;
    logic [LANES-1:0][WORK_W-1:0] r_work, n_work;
    logic [ROW_W-1:0] r_avail, n_avail;
    logic [ROW_W-1:0] r_old_avail, n_old_avail;
    logic [ROW_W-1:0] r_old_alloc, n_old_alloc;
    logic [ROW_W-1:0] r_amt, n_amt;
    logic r_granted, n_granted;
    logic r_safe, n_safe;
    logic [IW-1:0] r_order [NumProc];
    logic order_we;

    logic [ROW_W-1:0] in_amt;
    logic in_p_ok;
    logic accept;
    logic fits;
    logic exc_need;
    logic exc_avail;
    logic idx_last;
    logic scan_done;
    logic [ROW_W-1:0] sum_alloc;
    logic [ROW_W-1:0] dif_avail;
    logic [LANES-1:0][WORK_W-1:0] work_add;

    assign in_amt  = {i_in_data.amount_d, i_in_data.amount_c,
                      i_in_data.amount_b, i_in_data.amount_a};
    assign in_p_ok = ({1'b0, i_in_data.process} < (PROC_W + 1)'(NumProc));
    assign o_in_ready = (r_state == S_IDLE) && i_res_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign idx_last   = (r_idx == IW'(NumProc - 1));

    always_comb begin
        fits      = !r_fin[r_idx];
        exc_need  = 1'b0;
        exc_avail = 1'b0;
        for (int k = 0; k < LANES; k++) begin
            if (WORK_W'(need_of(lane_of(i_max_q, k), lane_of(i_alloc_q, k))) > r_work[k]) begin
                fits = 1'b0;
            end
            if (lane_of(r_amt, k) > need_of(lane_of(i_max_q, k), lane_of(i_alloc_q, k))) begin
                exc_need = 1'b1;
            end
            if (lane_of(r_amt, k) > lane_of(r_avail, k)) begin
                exc_avail = 1'b1;
            end
            work_add[k] = r_work[k] + WORK_W'(lane_of(i_alloc_q, k));
            sum_alloc[k*LANE_W +: LANE_W] = lane_of(i_alloc_q, k) + lane_of(r_amt, k);
            dif_avail[k*LANE_W +: LANE_W] = lane_of(r_avail, k) - lane_of(r_amt, k);
        end
    end

    assign scan_done = !fits && idx_last;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_p         = r_p;
        n_epos      = r_epos;
        n_cnt       = r_cnt;
        n_fin       = r_fin;
        n_work      = r_work;
        n_avail     = r_avail;
        n_old_avail = r_old_avail;
        n_old_alloc = r_old_alloc;
        n_amt       = r_amt;
        n_granted   = r_granted;
        n_safe      = r_safe;
        order_we    = 1'b0;
        o_cmd       = '0;
        o_cmd.rd_addr = PROC_W'(r_p);
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.last_item = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                o_cmd.rd_addr = i_in_data.process;
                o_cmd.wr_addr = i_in_data.process;
                o_cmd.wr_data = in_amt;
                if (accept) begin
                    n_amt     = in_amt;
                    n_p       = i_in_data.process[IW-1:0];
                    n_granted = 1'b0;
                    case (i_in_data.func)
                        FN_LOAD_AVAIL: begin
                            n_avail      = in_amt;
                            o_res_valid  = 1'b1;
                            o_res.status = ST_LOADED;
                        end
                        FN_CHECK: begin
                            n_state = S_START;
                        end
                        FN_LOAD_MAX, FN_LOAD_ALLOC, FN_REQUEST: begin
                            if (!in_p_ok) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_BAD_PROC;
                            end else if (i_in_data.func == FN_REQUEST) begin
                                n_state = S_REQ;
                            end else begin
                                o_cmd.we_max   = (i_in_data.func == FN_LOAD_MAX);
                                o_cmd.we_alloc = (i_in_data.func == FN_LOAD_ALLOC);
                                o_res_valid    = 1'b1;
                                o_res.status   = ST_LOADED;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_REQ: begin
                o_cmd.wr_addr = PROC_W'(r_p);
                o_cmd.wr_data = sum_alloc;
                if (exc_need || exc_avail) begin
                    o_res_valid  = 1'b1;
                    o_res.status = exc_need ? ST_EXC_NEED : ST_EXC_AVAIL;
                    if (i_res_ready) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.we_alloc = 1'b1;
                    n_old_alloc    = i_alloc_q;
                    n_old_avail    = r_avail;
                    n_avail        = dif_avail;
                    n_granted      = 1'b1;
                    n_state        = S_START;
                end
            end
            S_START: begin
                o_cmd.rd_addr = '0;
                n_idx   = '0;
                n_cnt   = '0;
                n_fin   = '0;
                for (int k = 0; k < LANES; k++) begin
                    n_work[k] = WORK_W'(lane_of(r_avail, k));
                end
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (fits) begin
                    n_work       = work_add;
                    n_fin[r_idx] = 1'b1;
                    order_we     = 1'b1;
                    n_cnt        = r_cnt + 1'b1;
                    n_idx        = '0;
                end else if (!idx_last) begin
                    n_idx = r_idx + 1'b1;
                end
                o_cmd.rd_addr = PROC_W'(n_idx);
                if (scan_done) begin
                    n_safe  = (r_cnt == CW'(NumProc));
                    n_epos  = '0;
                    n_state = S_EMIT;
                    if (r_cnt != CW'(NumProc) && r_granted) begin
                        o_cmd.we_alloc = 1'b1;
                        o_cmd.wr_addr  = PROC_W'(r_p);
                        o_cmd.wr_data  = r_old_alloc;
                        n_avail        = r_old_avail;
                    end
                end
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                if (r_safe) begin
                    o_res.status       = ST_SAFE;
                    o_res.seq_position = PROC_W'(r_epos);
                    o_res.process_id   = PROC_W'(r_order[r_epos]);
                    o_res.last_item    = (r_epos == IW'(NumProc - 1));
                end else begin
                    o_res.status = ST_UNSAFE;
                end
                if (i_res_ready) begin
                    if (o_res.last_item) begin
                        n_state = S_IDLE;
                    end else begin
                        n_epos = r_epos + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_epos    <= '0;
            r_cnt     <= '0;
            r_fin     <= '0;
            r_work    <= '0;
            r_avail   <= '0;
            r_granted <= 1'b0;
            r_safe    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_epos    <= n_epos;
            r_cnt     <= n_cnt;
            r_fin     <= n_fin;
            r_work    <= n_work;
            r_avail   <= n_avail;
            r_granted <= n_granted;
            r_safe    <= n_safe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p         <= n_p;
        r_amt       <= n_amt;
        r_old_avail <= n_old_avail;
        r_old_alloc <= n_old_alloc;
        if (order_we) begin
            r_order[r_cnt[IW-1:0]] <= r_idx;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NumProc))
        else $error("pick count beyond process count");
    a_fin_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ($countones(r_fin) == int'(r_cnt)))
        else $error("finished flags disagree with pick count");
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_done) |=> (r_state == S_EMIT))
        else $error("scan end did not move to emit");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("request taken while busy");
`endif

endmodule
`default_nettype wire

// ===== hdl/bankers_safety_and_request_top.sv =====
// ----------------------------------------------------------------------------
// Banker's safety and request: top level
// Deadlock-avoidance checker for four resource types with registered output.
//
//   channel  dir  payload     accepted when
//   i_req    in   t_in_item   i_req.valid & i_req.ready
//   o_rsp    out  t_out_item  o_rsp.valid & o_rsp.ready
//
// Loads and bad-process requests are answered from the idle state. A safety
// check scans at most N*(N+3)/2 table rows; its results then leave one per
// cycle while the output is not stalled. A request reads its process's rows
// before its checks. Reset is synchronous and clears the tables through
// per-row valid bits. A stalled output holds the sequencer while it has a
// result to give and keeps it from taking new requests.
// ----------------------------------------------------------------------------
`default_nettype none
module bankers_safety_and_request_top #(
    parameter int NUM_PROCESSES = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bsr_chan_if.sink   i_req,
    bsr_chan_if.source o_rsp
);
    import bsr_pkg::*;

    t_tbl_cmd  cmd;
    t_out_item res;
    t_out_item r_odata;
    logic      r_ovalid;
    logic      res_valid;
    logic      res_ready;
    logic [31:0] max_q;
    logic [31:0] alloc_q;

    assign res_ready = !r_ovalid || o_rsp.ready;

    bsr_tables #(.NumProc(NUM_PROCESSES)) u_tables (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_max_q   (max_q),
        .o_alloc_q (alloc_q)
    );

    bsr_ctrl #(.NumProc(NUM_PROCESSES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_in_data   (i_req.data),
        .o_cmd       (cmd),
        .i_max_q     (max_q),
        .i_alloc_q   (alloc_q),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_odata <= res;
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_odata;

endmodule
`default_nettype wire

// ===== tb/sv/tb_bankers_safety_and_request_top.sv =====
// ----------------------------------------------------------------------------
// Banker's safety and request: testbench
// Drives load, check, request and unused-code items with random gaps and output
// stalls, predicts the safe order or status, if any, of every item and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_bankers_safety_and_request_top;
    import bsr_pkg::*;

    localparam int NPROC = 8;
    localparam logic [2:0] FN_UNUSED = 3'd5;

    class bsr_scoreboard;
        logic [ROW_W-1:0] max_rows [NPROC];
        logic [ROW_W-1:0] alloc_rows [NPROC];
        logic [ROW_W-1:0] avail;
        t_out_item        pending [$];
        int               errors;
        int               n_checked;

        function void clear();
            for (int i = 0; i < NPROC; i++) begin
                max_rows[i] = '0;
                alloc_rows[i] = '0;
            end
            avail = '0;
        endfunction

        function void push(logic [2:0] st, int pos, int pid, bit last);
            t_out_item o;
            o.status = st;
            o.seq_position = PROC_W'(pos);
            o.process_id = PROC_W'(pid);
            o.last_item = last;
            pending.push_back(o);
        endfunction

        function int lane_val(logic [ROW_W-1:0] v, int k);
            return int'(v[k*LANE_W +: LANE_W]);
        endfunction

        function int safe_order();
            int w [LANES];
            bit fin [NPROC];
            int order [NPROC];
            int cnt;
            int pick;
            bit fits;
            int nd;
            cnt = 0;
            for (int k = 0; k < LANES; k++) w[k] = lane_val(avail, k);
            for (int i = 0; i < NPROC; i++) fin[i] = 0;
            forever begin
                pick = -1;
                for (int i = 0; i < NPROC && pick < 0; i++) begin
                    if (!fin[i]) begin
                        fits = 1;
                        for (int k = 0; k < LANES; k++) begin
                            nd = lane_val(max_rows[i], k) - lane_val(alloc_rows[i], k);
                            if (nd < 0) nd = 0;
                            if (nd > w[k]) fits = 0;
                        end
                        if (fits) pick = i;
                    end
                end
                if (pick < 0) break;
                for (int k = 0; k < LANES; k++)
                    w[k] = (w[k] + lane_val(alloc_rows[pick], k)) & 13'h1fff;
                fin[pick] = 1;
                order[cnt] = pick;
                cnt++;
            end
            if (cnt != NPROC) begin
                push(ST_UNSAFE, 0, 0, 1);
                return 0;
            end
            for (int i = 0; i < NPROC; i++) push(ST_SAFE, i, order[i], i == NPROC - 1);
            return 1;
        endfunction

        function void note_request(t_in_item it);
            logic [ROW_W-1:0] amt;
            logic [ROW_W-1:0] old_av;
            logic [ROW_W-1:0] old_al;
            int p;
            int nd;
            bit bad;
            amt = {it.amount_d, it.amount_c, it.amount_b, it.amount_a};
            p = it.process;
            if (it.func > FN_REQUEST) return;
            if (it.func == FN_LOAD_AVAIL) begin
                avail = amt;
                push(ST_LOADED, 0, 0, 1);
                return;
            end
            if (it.func == FN_CHECK) begin
                void'(safe_order());
                return;
            end
            if (p >= NPROC) begin
                push(ST_BAD_PROC, 0, 0, 1);
                return;
            end
            if (it.func == FN_LOAD_MAX || it.func == FN_LOAD_ALLOC) begin
                if (it.func == FN_LOAD_MAX) max_rows[p] = amt;
                else alloc_rows[p] = amt;
                push(ST_LOADED, 0, 0, 1);
                return;
            end
            bad = 0;
            for (int k = 0; k < LANES; k++) begin
                nd = lane_val(max_rows[p], k) - lane_val(alloc_rows[p], k);
                if (nd < 0) nd = 0;
                if (lane_val(amt, k) > nd) bad = 1;
            end
            if (bad) begin
                push(ST_EXC_NEED, 0, 0, 1);
                return;
            end
            for (int k = 0; k < LANES; k++)
                if (lane_val(amt, k) > lane_val(avail, k)) bad = 1;
            if (bad) begin
                push(ST_EXC_AVAIL, 0, 0, 1);
                return;
            end
            old_av = avail;
            old_al = alloc_rows[p];
            for (int k = 0; k < LANES; k++) begin
                avail[k*LANE_W +: LANE_W] = old_av[k*LANE_W +: LANE_W] - amt[k*LANE_W +: LANE_W];
                alloc_rows[p][k*LANE_W +: LANE_W] =
                    old_al[k*LANE_W +: LANE_W] + amt[k*LANE_W +: LANE_W];
            end
            if (!safe_order()) begin
                avail = old_av;
                alloc_rows[p] = old_al;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_item;
            n_checked++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
                return;
            end
            exp_item = pending.pop_front();
            if (got.status !== exp_item.status)
                report_mismatch($sformatf("status %0d, wanted %0d", got.status, exp_item.status));
            if (got.seq_position !== exp_item.seq_position)
                report_mismatch($sformatf("seq_position %0d, wanted %0d",
                                          got.seq_position, exp_item.seq_position));
            if (got.process_id !== exp_item.process_id)
                report_mismatch($sformatf("process_id %0d, wanted %0d",
                                          got.process_id, exp_item.process_id));
            if (got.last_item !== exp_item.last_item)
                report_mismatch($sformatf("last_item %0d, wanted %0d",
                                          got.last_item, exp_item.last_item));
        endfunction

        function void report_mismatch(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bsr_chan_if #(.T(t_in_item))  req_if ();
    bsr_chan_if #(.T(t_out_item)) rsp_if ();

    bankers_safety_and_request_top #(.NUM_PROCESSES(NPROC)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    bsr_scoreboard ledger;
    int  cycle_count;
    int  n_sent;
    int  n_safe;
    int  n_unsafe;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (rsp_if.data.status == ST_SAFE && rsp_if.data.last_item) n_safe++;
            if (rsp_if.data.status == ST_UNSAFE) n_unsafe++;
            ledger.check_result(rsp_if.data);
        end
    end

    // random output stalls
    initial begin
        int gap;
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            rsp_if.ready = 1'b0;
            repeat (gap) @(negedge i_clk);
            rsp_if.ready = 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
        end
    end

    task automatic send_request(logic [2:0] fn, logic [3:0] p,
                                logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d,
                                bit no_gap = 0);
        t_in_item it;
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        it.func = fn;
        it.process = p;
        it.amount_a = a;
        it.amount_b = b;
        it.amount_c = c;
        it.amount_d = d;
        req_if.data = it;
        req_if.valid = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        ledger.note_request(it);
        n_sent++;
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    task automatic send_row(logic [2:0] fn, int p, int lim);
        send_request(fn, 4'(p), 8'($urandom_range(0, lim)), 8'($urandom_range(0, lim)),
                     8'($urandom_range(0, lim)), 8'($urandom_range(0, lim)));
    endtask

    // random scenario: well-formed claims, allocations, availability, then traffic
    task automatic run_scenario(int lim);
        int p;
        int n_ops;
        for (int i = 0; i < NPROC; i++) send_row(FN_LOAD_MAX, i, lim);
        for (int i = 0; i < NPROC; i++) send_row(FN_LOAD_ALLOC, i, lim / 2);
        send_row(FN_LOAD_AVAIL, $urandom_range(0, 15), lim);
        n_ops = $urandom_range(4, 12);
        for (int j = 0; j < n_ops; j++) begin
            p = $urandom_range(0, 9);
            case ($urandom_range(0, 9))
                0: send_row(FN_CHECK, $urandom_range(0, 15), 255);
                1: send_row(FN_LOAD_AVAIL, 0, lim);
                2: send_request(3'($urandom_range(FN_UNUSED, 7)), 4'($urandom_range(0, 15)),
                                8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                3: send_row(FN_REQUEST, p, 255);
                default: send_row(FN_REQUEST, p, lim / 4 + 1);
            endcase
        end
    endtask

    initial begin
        int lim;
        int wait_cycles;
        ledger = new();
        ledger.clear();
        cycle_count = 0;
        n_sent = 0;
        n_safe = 0;
        n_unsafe = 0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty state is safe, loads, errors, extremes, ignored codes
        send_request(FN_CHECK, 0, 0, 0, 0, 0);
        send_request(FN_LOAD_MAX, 15, 8'hff, 8'hff, 8'hff, 8'hff);
        send_request(FN_LOAD_ALLOC, 8, 1, 2, 3, 4);
        send_request(FN_REQUEST, 9, 0, 0, 0, 0);
        send_request(3'd5, 3, 1, 1, 1, 1);
        send_request(3'd7, 0, 8'hff, 0, 0, 0);
        send_request(FN_LOAD_MAX, 0, 8'hff, 8'hff, 8'hff, 8'hff, 1);
        send_request(FN_LOAD_MAX, 7, 8'h0f, 8'hf0, 8'haa, 8'h55, 1);
        send_request(FN_LOAD_ALLOC, 7, 8'hff, 8'hff, 8'hff, 8'hff, 1);
        send_request(FN_LOAD_AVAIL, 15, 8'h10, 8'h10, 8'h10, 8'h10);
        send_request(FN_REQUEST, 7, 1, 0, 0, 0);
        send_request(FN_REQUEST, 0, 8'h20, 0, 0, 0);
        send_request(FN_REQUEST, 0, 8'h10, 8'h10, 8'h10, 8'h10);
        send_request(FN_CHECK, 0, 0, 0, 0, 0);
        send_request(FN_LOAD_AVAIL, 0, 8'hff, 8'hff, 8'hff, 8'hff);
        send_request(FN_CHECK, 0, 0, 0, 0, 0);
        send_request(FN_REQUEST, 0, 1, 1, 1, 1);
        send_request(FN_LOAD_MAX, 7, 0, 0, 0, 0);
        send_request(FN_REQUEST, 7, 0, 0, 0, 0);
        send_request(FN_LOAD_AVAIL, 0, 0, 0, 0, 0);
        send_request(FN_CHECK, 0, 0, 0, 0, 0);

        // random scenarios, mostly small amounts so both outcomes appear
        while (n_sent < 385) begin
            case ($urandom_range(0, 3))
                0: lim = 255;
                1: lim = 40;
                default: lim = 12;
            endcase
            run_scenario(lim);
        end

        wait_cycles = 0;
        while (ledger.pending.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);

        $display("sent %0d requests, checked %0d results", n_sent, ledger.n_checked);
        $display("safe orders seen %0d, unsafe outcomes seen %0d", n_safe, n_unsafe);
        if (ledger.errors == 0 && ledger.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            if (ledger.pending.size() != 0)
                $display("%0d results never arrived", ledger.pending.size());
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
